// ----- rtl/hsfc_pkg.sv -----
// shared item kinds and stage record types for the half/single converter
package hsfc_pkg;

    // what kind of result an item produces, decided in the first stage
    localparam logic [3:0] KIND_ZERO        = 4'd0;
    localparam logic [3:0] KIND_EXP_SPECIAL = 4'd1;
    localparam logic [3:0] KIND_EXP_NORM    = 4'd2;
    localparam logic [3:0] KIND_EXP_SMOOTH  = 4'd3;
    localparam logic [3:0] KIND_EXP_SUB     = 4'd4;
    localparam logic [3:0] KIND_CMP_INF     = 4'd5;
    localparam logic [3:0] KIND_CMP_SAT     = 4'd6;
    localparam logic [3:0] KIND_CMP_NORM    = 4'd7;
    localparam logic [3:0] KIND_CMP_SUB     = 4'd8;

    // direction select carried on the input tuser
    localparam logic FUNC_EXPAND   = 1'b0;
    localparam logic FUNC_COMPRESS = 1'b1;

    // record after classification
    typedef struct packed {
        logic        func;
        logic        sign;
        logic [3:0]  kind;
        logic [7:0]  expo;
        logic [22:0] frac;
        logic [3:0]  lz;
    } s1_t;

    // record after the main arithmetic
    typedef struct packed {
        logic        func;
        logic        sign;
        logic [3:0]  kind;
        logic [24:0] word;
        logic [4:0]  sh;
    } s2_t;

endpackage

// ----- rtl/hsfc_decode.sv -----
// first stage: classifies the item and does the rounding add
module hsfc_decode (
    input  logic              aclk,
    input  logic              en,
    input  logic              func,
    input  logic [31:0]       value_in,
    output hsfc_pkg::s1_t     s1
);

    // magnitude thresholds; the rounding ones have the rounding increment already taken off
    localparam logic [30:0] MAG_TO_INF  = 31'h477ff000;
    localparam logic [30:0] MAG_INF     = 31'h47800000;
    localparam logic [30:0] MAG_NAN_INF = 31'h7f800000;
    localparam logic [30:0] MAG_NORMAL  = 31'h387ff000;
    localparam logic [30:0] MAG_TINY    = 31'h32fff000;
    localparam logic [7:0]  SUB_EXP_LO  = 8'd102;
    localparam logic [7:0]  SUB_EXP_HI  = 8'd112;

    hsfc_pkg::s1_t rec_reg;
    hsfc_pkg::s1_t rec_next;

    logic [4:0]  e5;
    logic [9:0]  hm;
    logic [30:0] mag;
    logic [31:0] val;
    logic [7:0]  fe;

    // shifts needed to bring the top set bit of a subnormal mantissa to bit 10
    function automatic logic [3:0] norm_shift(input logic [9:0] m);
        logic [3:0] n;
        logic       found;
        n     = 4'd0;
        found = 1'b0;
        for (int i = 9; i >= 0; i--) begin
            if (!found && m[i]) begin
                n     = 4'(10 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    assign e5  = value_in[14:10];
    assign hm  = value_in[9:0];
    assign mag = value_in[30:0];
    assign val = {1'b0, mag} + 32'h00001000;
    assign fe  = value_in[30:23];

    // classification for both directions
    always_comb begin
        rec_next      = '0;
        rec_next.func = func;
        if (func == hsfc_pkg::FUNC_EXPAND) begin
            rec_next.sign = value_in[15];
            rec_next.expo = {3'b000, e5};
            rec_next.frac = {13'b0, hm};
            rec_next.lz   = norm_shift(hm);
            if (e5 == 5'h1f) begin
                rec_next.kind = hsfc_pkg::KIND_EXP_SPECIAL;
            end else if (e5 != 5'h00) begin
                if (hm == 10'h000 && e5 >= 5'd2) begin
                    rec_next.kind = hsfc_pkg::KIND_EXP_SMOOTH;
                end else begin
                    rec_next.kind = hsfc_pkg::KIND_EXP_NORM;
                end
            end else if (hm != 10'h000) begin
                rec_next.kind = hsfc_pkg::KIND_EXP_SUB;
            end else begin
                rec_next.kind = hsfc_pkg::KIND_ZERO;
            end
        end else begin
            rec_next.sign = value_in[31];
            rec_next.expo = fe;
            if (mag >= MAG_TO_INF) begin
                if (mag >= MAG_INF) begin
                    rec_next.kind = hsfc_pkg::KIND_CMP_INF;
                    // nan payload survives, finite overflow gives plain inf
                    rec_next.frac = (mag >= MAG_NAN_INF) ? {13'b0, value_in[22:13]} : '0;
                end else begin
                    rec_next.kind = hsfc_pkg::KIND_CMP_SAT;
                end
            end else if (mag >= MAG_NORMAL) begin
                rec_next.kind = hsfc_pkg::KIND_CMP_NORM;
                rec_next.frac = {8'b0, val[27:13]};
            end else if (mag < MAG_TINY) begin
                rec_next.kind = hsfc_pkg::KIND_ZERO;
            end else if (fe < SUB_EXP_LO || fe > SUB_EXP_HI) begin
                rec_next.kind = hsfc_pkg::KIND_ZERO;
            end else begin
                rec_next.kind = hsfc_pkg::KIND_CMP_SUB;
                rec_next.frac = value_in[22:0];
            end
        end
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (en) begin
            rec_reg <= rec_next;
        end
    end

    assign s1 = rec_reg;

endmodule

// ----- rtl/hsfc_compute.sv -----
// second stage: rebias, normalize shift and subnormal rounding add
module hsfc_compute (
    input  logic              aclk,
    input  logic              en,
    input  hsfc_pkg::s1_t     s1,
    output hsfc_pkg::s2_t     s2
);

    localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;
    localparam logic [7:0]  EXP_SUB_BASE  = 8'd113;
    localparam logic [7:0]  SUB_EXP_LO    = 8'd102;
    localparam logic [7:0]  SUB_SHIFT_TOP = 8'd126;
    localparam logic [14:0] HALF_REBIAS   = 15'h4000;
    localparam logic [14:0] HALF_INF      = 15'h7c00;
    localparam logic [14:0] HALF_MAX      = 15'h7bff;
    localparam logic [24:0] SUB_ROUND_ONE = 25'h0800000;

    hsfc_pkg::s2_t rec_reg;
    hsfc_pkg::s2_t rec_next;

    logic [3:0] sub_amt;
    logic [7:0] sub_exp;
    logic [9:0] sub_mant;

    assign sub_amt  = 4'(s1.expo - SUB_EXP_LO);
    assign sub_exp  = EXP_SUB_BASE - {4'b0000, s1.lz};
    assign sub_mant = 10'(s1.frac[9:0] << s1.lz);

    // per-kind arithmetic
    always_comb begin
        rec_next      = '0;
        rec_next.func = s1.func;
        rec_next.sign = s1.sign;
        rec_next.kind = s1.kind;
        unique case (s1.kind)
            hsfc_pkg::KIND_EXP_SPECIAL: begin
                rec_next.word = {7'b0, 8'hff, s1.frac[9:0]};
            end
            hsfc_pkg::KIND_EXP_NORM, hsfc_pkg::KIND_EXP_SMOOTH: begin
                rec_next.word = {7'b0, s1.expo + EXP_BIAS_DIFF, s1.frac[9:0]};
            end
            hsfc_pkg::KIND_EXP_SUB: begin
                rec_next.word = {7'b0, sub_exp, sub_mant};
            end
            hsfc_pkg::KIND_CMP_NORM: begin
                rec_next.word = {10'b0, s1.frac[14:0] - HALF_REBIAS};
            end
            hsfc_pkg::KIND_CMP_INF: begin
                rec_next.word = {10'b0, HALF_INF | {5'b0, s1.frac[9:0]}};
            end
            hsfc_pkg::KIND_CMP_SAT: begin
                rec_next.word = {10'b0, HALF_MAX};
            end
            hsfc_pkg::KIND_CMP_SUB: begin
                rec_next.word = {2'b01, s1.frac} + (SUB_ROUND_ONE >> sub_amt);
                rec_next.sh   = 5'(SUB_SHIFT_TOP - s1.expo);
            end
            default: begin
                rec_next.word = '0;
            end
        endcase
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (en) begin
            rec_reg <= rec_next;
        end
    end

    assign s2 = rec_reg;

endmodule

// ----- rtl/hsfc_assemble.sv -----
// third stage: subnormal alignment shift and packing into the output register
module hsfc_assemble (
    input  logic              aclk,
    input  logic              en,
    input  hsfc_pkg::s2_t     s2,
    output logic [31:0]       value_out
);

    logic [31:0] out_reg;
    logic [31:0] out_next;
    logic [24:0] sub_shifted;
    logic [15:0] sub_half;

    assign sub_shifted = s2.word >> s2.sh;
    assign sub_half    = {s2.sign, 15'b0} | sub_shifted[15:0];

    // final bit pattern per kind
    always_comb begin
        unique case (s2.kind)
            hsfc_pkg::KIND_ZERO: begin
                out_next = (s2.func == hsfc_pkg::FUNC_COMPRESS) ?
                           {16'b0, s2.sign, 15'b0} : {s2.sign, 31'b0};
            end
            hsfc_pkg::KIND_EXP_SPECIAL, hsfc_pkg::KIND_EXP_NORM,
            hsfc_pkg::KIND_EXP_SUB: begin
                out_next = {s2.sign, s2.word[17:0], 13'b0};
            end
            hsfc_pkg::KIND_EXP_SMOOTH: begin
                out_next = {s2.sign, s2.word[17:10], 13'b0, 10'h3ff};
            end
            hsfc_pkg::KIND_CMP_NORM, hsfc_pkg::KIND_CMP_INF,
            hsfc_pkg::KIND_CMP_SAT: begin
                out_next = {16'b0, s2.sign, s2.word[14:0]};
            end
            hsfc_pkg::KIND_CMP_SUB: begin
                out_next = {16'b0, sub_half};
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign value_out = out_reg;

endmodule

// ----- rtl/half_single_float_converter.sv -----
// top level of the half/single float converter: stage control and valid tracking
//
// Converts IEEE 754 bit patterns between half and single precision, one item
// at a time on a stream input and a stream output.
// Input: s_tuser selects the direction (0 expands half to single, 1 compresses
// single to half); s_tdata carries the pattern, a half in the low 16 bits.
// Output: m_tdata carries the result; a half result has the upper 16 bits zero.
// Compression rounds half up, saturates or gives inf on overflow, keeps nan
// payload bits and flushes tiny values to signed zero.
// Stages: classify and rounding add, rebias or normalize or subnormal add, then
// alignment shift into the output register. Throughput is one item per cycle
// while the receiver keeps m_tready high; each stage holds one item.
// When the receiver holds m_tready low the stages fill up one by one and
// s_tready drops once all three hold an item; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties all stages; no item is in flight
// afterward and the block takes input at once.
module half_single_float_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value_in[31:0]
    input  logic        s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // value_out[31:0]
);

    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic v3_reg;
    logic v3_next;
    logic ready1;
    logic ready2;
    logic ready3;

    hsfc_pkg::s1_t s1;
    hsfc_pkg::s2_t s2;

    // a stage may load when it is empty or its item moves on
    assign ready3 = !v3_reg || m_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign v1_next = ready1 ? s_tvalid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;
    assign v3_next = ready3 ? v2_reg : v3_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    hsfc_decode u_decode (
        .aclk     (aclk),
        .en       (ready1),
        .func     (s_tuser),
        .value_in (s_tdata),
        .s1       (s1)
    );

    hsfc_compute u_compute (
        .aclk (aclk),
        .en   (ready2),
        .s1   (s1),
        .s2   (s2)
    );

    hsfc_assemble u_assemble (
        .aclk      (aclk),
        .en        (ready3),
        .s2        (s2),
        .value_out (m_tdata)
    );

    assign s_tready = ready1;
    assign m_tvalid = v3_reg;

    // input back-pressure only when every stage holds an item and output is stalled
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled while pipeline has room");

    // a held first-stage item keeps its record
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !ready2) |=> $stable(s1))
        else $error("stalled stage one record changed");

    // a held second-stage item keeps its record
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !ready3) |=> $stable(s2))
        else $error("stalled stage two record changed");

endmodule

// ----- test/tb.sv -----
// self-checking stream testbench for the half/single float converter
module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SUB_EXP_BASE = 102;
    localparam int RAND_ITEMS   = 306;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = hsfc_pkg::FUNC_EXPAND;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    logic [31:0] expected_words[$];
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          mismatch_count = 0;
    int          checked_count = 0;
    int          expand_count = 0;
    int          compress_count = 0;
    int          cycle_count = 0;

    half_single_float_converter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock, period 4
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // exact widening of a half pattern, smoothing of zero mantissas included
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic       sgn;
        logic [4:0] hexp;
        logic [9:0] hman;
        logic [7:0] fexp;
        logic [10:0] norm;
        int         shifts;
        sgn  = h[15];
        hexp = h[14:10];
        hman = h[9:0];
        if (hexp == 5'h1f)
            return {sgn, 8'hff, hman, 13'b0};
        if (hexp != 5'h0) begin
            fexp = 8'(hexp) + 8'd112;
            if (hman == 10'h0 && hexp >= 5'd2)
                return {sgn, fexp, 23'h3ff};
            return {sgn, fexp, hman, 13'b0};
        end
        if (hman != 10'h0) begin
            norm = {1'b0, hman};
            shifts = 0;
            while (!norm[10]) begin
                norm = norm << 1;
                shifts++;
            end
            fexp = 8'(113 - shifts);
            return {sgn, fexp, norm[9:0], 13'b0};
        end
        return {sgn, 31'b0};
    endfunction

    // narrowing of a single pattern with round half up, saturation and flush
    function automatic logic [15:0] narrow_single(input logic [31:0] f);
        logic [15:0] sgn;
        logic [31:0] mag;
        logic [31:0] rnd;
        logic [31:0] m;
        logic [31:0] tmp;
        int          e;
        sgn = {f[31], 15'b0};
        mag = {1'b0, f[30:0]};
        rnd = mag + 32'h1000;
        if (rnd >= 32'h4780_0000) begin
            if (mag >= 32'h4780_0000) begin
                if (mag < 32'h7f80_0000)
                    return sgn | 16'h7c00;
                return sgn | 16'h7c00 | {6'b0, f[22:13]};
            end
            return sgn | 16'h7bff;
        end
        if (rnd >= 32'h3880_0000) begin
            tmp = (rnd - 32'h3800_0000) >> 13;
            return sgn | {1'b0, tmp[14:0]};
        end
        if (rnd < 32'h3300_0000)
            return sgn;
        e = int'(mag[30:23]);
        if (e < SUB_EXP_BASE || e > 112)
            return sgn;
        m = {9'b0, f[22:0]} | 32'h0080_0000;
        m = m + (32'h0080_0000 >> (e - SUB_EXP_BASE));
        tmp = m >> (126 - e);
        return sgn | tmp[15:0];
    endfunction

    // offer one item, with random gaps before it, and record its expected result
    task automatic send_item(input logic func, input logic [31:0] value);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= value;
        do
            @(posedge aclk);
        while (!s_tready);
        if (func == hsfc_pkg::FUNC_EXPAND) begin
            expected_words.push_back(widen_half(value[15:0]));
            expand_count++;
        end else begin
            expected_words.push_back({16'b0, narrow_single(value)});
            compress_count++;
        end
    endtask

    // receiver stalls
    always @(posedge aclk)
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // compare each result against the oldest expectation
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("value_out: unexpected result, expected none, got %h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                checked_count++;
                if (m_tdata !== want) begin
                    $error("value_out: expected %h, got %h", want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("half_single_float_converter regression: fail");
            $finish;
        end
    end

    // half corner values: zeros, subnormals, smoothing, inf, nan, junk upper bits
    task automatic test_expand_edges();
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_0000);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_8000);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_0001);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'hffff_83ff);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_0200);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_0400);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_8800);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'hffff_3c00);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_3c01);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_7bff);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h0000_fc00);
        send_item(hsfc_pkg::FUNC_EXPAND, 32'h5a5a_7e01);
    endtask

    // single corner values: saturation, inf, nan payload, underflow, exponent 101
    task automatic test_compress_edges();
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h0000_0000);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h8000_0000);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h3f80_0000);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h477f_efff);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'hc77f_f000);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h4780_0000);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h7f7f_ffff);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'hff80_0000);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h7fff_ffff);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h387f_ffff);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h3800_0000);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h3300_0000);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'hb2ff_f800);
        send_item(hsfc_pkg::FUNC_COMPRESS, 32'h32ff_efff);
    endtask

    // random half pattern with random upper bits, biased toward exponent edges and zero mantissas
    function automatic logic [31:0] pick_half_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(3))
            0: ;
            1: w[14:10] = 5'h00;
            2: w[14:10] = 5'h1f;
            default: w[9:0] = 10'h0;
        endcase
        return w;
    endfunction

    // random single pattern aimed at each region of the narrowing
    function automatic logic [31:0] pick_single_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(5))
            0: ;
            // underflow and subnormal range
            1: w[30:23] = 8'($urandom_range(100, 113));
            // overflow and rounding into inf
            2: begin
                w[30:23] = 8'($urandom_range(140, 143));
                if ($urandom_range(1))
                    w[22:12] = 11'h7ff;
            end
            3: case ($urandom_range(2))
                0: w[30:23] = 8'hff;
                1: w[30:23] = 8'h00;
                default: w[30:23] = 8'hfe;
            endcase
            // rounding boundary in the normal range
            4: begin
                w[30:23] = 8'($urandom_range(112, 142));
                case ($urandom_range(2))
                    0: w[12:0] = 13'h0fff;
                    1: w[12:0] = 13'h1000;
                    default: w[12:0] = 13'h1fff;
                endcase
            end
            // carry out of the kept mantissa
            default: begin
                w[30:23] = 8'($urandom_range(101, 143));
                w[22:13] = 10'h3ff;
            end
        endcase
        return w;
    endfunction

    // random mix of both directions
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1))
                send_item(hsfc_pkg::FUNC_COMPRESS, pick_single_word());
            else
                send_item(hsfc_pkg::FUNC_EXPAND, pick_half_word());
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_expand_edges();
        test_compress_edges();

        // free flow
        send_gap_pct = 0;
        stall_pct = 0;
        test_random_traffic(RAND_ITEMS);
        // sender gaps
        send_gap_pct = 64;
        stall_pct = 0;
        test_random_traffic(RAND_ITEMS);
        // receiver stalls
        send_gap_pct = 0;
        stall_pct = 64;
        test_random_traffic(RAND_ITEMS);
        // light gaps on both sides
        send_gap_pct = 7;
        stall_pct = 7;
        test_random_traffic(RAND_ITEMS);

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d half-to-single and %0d single-to-half items, %0d results checked",
                 expand_count, compress_count, checked_count);
        $display("flow phases: free, sender gaps, receiver stalls, both light; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("half_single_float_converter regression: pass");
        else
            $display("half_single_float_converter regression: fail");
        $finish;
    end

endmodule
